// ===== hw/rtl/tgd_pkg.sv =====
// Shared types, constants and register map for the touch gesture detector.
package tgd_pkg;

  localparam int CoordBits = 12;
  localparam int DistBits = 12;
  localparam int HoldBits = 16;
  localparam int TimeBits = 32;
  localparam int DominanceNum = 3;
  localparam int DominanceDen = 2;
  localparam int CodeBits = 3;
  localparam int AddrBits = 5;
  localparam int DataBits = 32;

  localparam int CmpBits = (CoordBits > DistBits) ? CoordBits : DistBits;
  localparam int MulBits = CoordBits + 4;

  localparam logic [CodeBits-1:0] GestLeft = 3'd0;
  localparam logic [CodeBits-1:0] GestRight = 3'd1;
  localparam logic [CodeBits-1:0] GestDown = 3'd2;
  localparam logic [CodeBits-1:0] GestUp = 3'd3;
  localparam logic [CodeBits-1:0] GestLong = 3'd4;

  localparam logic [2:0] RegDetectEn = 3'd0;
  localparam logic [2:0] RegLongEn = 3'd1;
  localparam logic [2:0] RegSwipeMin = 3'd2;
  localparam logic [2:0] RegPullMin = 3'd3;
  localparam logic [2:0] RegSlop = 3'd4;
  localparam logic [2:0] RegLongTime = 3'd5;
  localparam logic [2:0] RegSwipeMax = 3'd6;
  localparam logic [2:0] RegCooldown = 3'd7;

  typedef struct packed {
    logic                detect_enabled;
    logic                long_press_enabled;
    logic [DistBits-1:0] swipe_min_distance;
    logic [DistBits-1:0] pull_min_distance;
    logic [DistBits-1:0] long_press_slop;
    logic [HoldBits-1:0] long_press_time;
    logic [HoldBits-1:0] swipe_max_time;
    logic [HoldBits-1:0] cooldown_time;
  } cfg_t;

  typedef struct packed {
    logic                 touch_pressed;
    logic [CoordBits-1:0] point_x;
    logic [CoordBits-1:0] point_y;
    logic [TimeBits-1:0]  now_ms;
    logic                 target_clickable;
  } item_t;

endpackage

// ===== hw/rtl/tgd_regs.sv =====
// APB configuration register file for the touch gesture detector.
module tgd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tgd_pkg::AddrBits-1:0] paddr,
  input  logic [tgd_pkg::DataBits-1:0] pwdata,
  output logic [tgd_pkg::DataBits-1:0] prdata,
  output logic                         pready,
  output tgd_pkg::cfg_t                cfg,
  output logic                         abandon
);
  import tgd_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[AddrBits-1:2];
  assign abandon = wr && (idx == RegDetectEn) && !pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_enabled <= 1'b1;
      cfg.long_press_enabled <= 1'b1;
      cfg.swipe_min_distance <= DistBits'(60);
      cfg.pull_min_distance <= DistBits'(80);
      cfg.long_press_slop <= DistBits'(10);
      cfg.long_press_time <= HoldBits'(800);
      cfg.swipe_max_time <= HoldBits'(500);
      cfg.cooldown_time <= HoldBits'(300);
    end else if (wr) begin
      case (idx)
        RegDetectEn: cfg.detect_enabled <= pwdata[0];
        RegLongEn: cfg.long_press_enabled <= pwdata[0];
        RegSwipeMin: cfg.swipe_min_distance <= pwdata[DistBits-1:0];
        RegPullMin: cfg.pull_min_distance <= pwdata[DistBits-1:0];
        RegSlop: cfg.long_press_slop <= pwdata[DistBits-1:0];
        RegLongTime: cfg.long_press_time <= pwdata[HoldBits-1:0];
        RegSwipeMax: cfg.swipe_max_time <= pwdata[HoldBits-1:0];
        RegCooldown: cfg.cooldown_time <= pwdata[HoldBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDetectEn: prdata = DataBits'(cfg.detect_enabled);
      RegLongEn: prdata = DataBits'(cfg.long_press_enabled);
      RegSwipeMin: prdata = DataBits'(cfg.swipe_min_distance);
      RegPullMin: prdata = DataBits'(cfg.pull_min_distance);
      RegSlop: prdata = DataBits'(cfg.long_press_slop);
      RegLongTime: prdata = DataBits'(cfg.long_press_time);
      RegSwipeMax: prdata = DataBits'(cfg.swipe_max_time);
      RegCooldown: prdata = DataBits'(cfg.cooldown_time);
      default: prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tgd_core.sv =====
// Press tracking state, gesture classification and result register.
module tgd_core (
  input  logic                         clk,
  input  logic                         rst,
  input  tgd_pkg::cfg_t                cfg,
  input  logic                         abandon,
  input  logic                         item_valid,
  input  tgd_pkg::item_t               item,
  output logic                         advance,
  input  logic                         gesture_stall,
  output logic                         gesture_valid,
  output logic [tgd_pkg::CodeBits-1:0] gesture_code
);
  import tgd_pkg::*;

  logic                 pressing, consumed, clickable_at_press, cooldown_armed;
  logic [CoordBits-1:0] origin_x, origin_y, recent_x, recent_y, peak_deviation;
  logic [TimeBits-1:0]  press_start_ms, cooldown_start_ms;

  logic                 proc, start, hold, release_now;
  logic [CoordBits-1:0] dx, dy, dev, peak_next, adx, ady;
  logic [TimeBits-1:0]  held_ms, cool_ms;
  logic                 cooling, long_fire, swipe_ok, hdom, vdom, h_hit, v_hit, fire;
  logic [MulBits-1:0]   adx_den, ady_num, ady_den, adx_num;
  logic [CodeBits-1:0]  code;

  function automatic logic [CoordBits-1:0] absdiff(input logic [CoordBits-1:0] a,
                                                   input logic [CoordBits-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign advance = !gesture_valid || !gesture_stall;
  assign proc = item_valid && advance;
  assign start = item.touch_pressed && !pressing;
  assign hold = item.touch_pressed && pressing;
  assign release_now = !item.touch_pressed && pressing;

  always_comb begin
    dx = absdiff(item.point_x, origin_x);
    dy = absdiff(item.point_y, origin_y);
    dev = (dx > dy) ? dx : dy;
    peak_next = (dev > peak_deviation) ? dev : peak_deviation;
    held_ms = item.now_ms - press_start_ms;
    cool_ms = item.now_ms - cooldown_start_ms;
    cooling = cooldown_armed && (cool_ms < TimeBits'(cfg.cooldown_time));

    long_fire = hold && !consumed && cfg.detect_enabled && cfg.long_press_enabled &&
                !clickable_at_press && !cooling &&
                (CmpBits'(peak_next) <= CmpBits'(cfg.long_press_slop)) &&
                (held_ms >= TimeBits'(cfg.long_press_time));

    adx = absdiff(recent_x, origin_x);
    ady = absdiff(recent_y, origin_y);
    adx_den = MulBits'(adx) * MulBits'(DominanceDen);
    adx_num = MulBits'(adx) * MulBits'(DominanceNum);
    ady_den = MulBits'(ady) * MulBits'(DominanceDen);
    ady_num = MulBits'(ady) * MulBits'(DominanceNum);
    hdom = adx_den > ady_num;
    vdom = ady_den > adx_num;
    h_hit = hdom && (CmpBits'(adx) >= CmpBits'(cfg.swipe_min_distance));
    v_hit = vdom && (CmpBits'(ady) >= CmpBits'(cfg.pull_min_distance));
    swipe_ok = release_now && !consumed && cfg.detect_enabled && !cooling &&
               (held_ms <= TimeBits'(cfg.swipe_max_time));

    if (long_fire) begin
      code = GestLong;
    end else if (h_hit) begin
      code = (recent_x < origin_x) ? GestLeft : GestRight;
    end else begin
      code = (recent_y > origin_y) ? GestDown : GestUp;
    end
    fire = long_fire || (swipe_ok && (h_hit || v_hit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressing <= 1'b0;
      consumed <= 1'b0;
      clickable_at_press <= 1'b0;
      cooldown_armed <= 1'b0;
      origin_x <= '0;
      origin_y <= '0;
      recent_x <= '0;
      recent_y <= '0;
      peak_deviation <= '0;
      press_start_ms <= '0;
      cooldown_start_ms <= '0;
      gesture_valid <= 1'b0;
    end else begin
      if (abandon) begin
        pressing <= 1'b0;
        consumed <= 1'b0;
      end else if (proc) begin
        if (start) begin
          pressing <= 1'b1;
          consumed <= 1'b0;
          origin_x <= item.point_x;
          origin_y <= item.point_y;
          recent_x <= item.point_x;
          recent_y <= item.point_y;
          press_start_ms <= item.now_ms;
          peak_deviation <= '0;
          clickable_at_press <= item.target_clickable;
        end else if (hold) begin
          recent_x <= item.point_x;
          recent_y <= item.point_y;
          peak_deviation <= peak_next;
          if (long_fire) begin
            consumed <= 1'b1;
          end
        end else if (release_now) begin
          pressing <= 1'b0;
          consumed <= 1'b0;
        end
        if (fire) begin
          cooldown_armed <= 1'b1;
          cooldown_start_ms <= item.now_ms;
        end
      end
      if (advance) begin
        gesture_valid <= proc && fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && fire) begin
      gesture_code <= code;
    end
  end

endmodule

// ===== hw/rtl/touch_gesture_detector.sv =====
// Top level of the touch gesture detector: input register, core and registers.
//
//   Channel    Direction  Signals
//   touch      in         touch_valid, touch_stall, touch_pressed, point_x, point_y,
//                         now_ms, target_clickable
//   gesture    out        gesture_valid, gesture_stall, gesture_code
//   config     in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A request is registered on acceptance and classified from the input register
// into the result register, and one request is taken per cycle while touch_stall
// is low. The result register holds a gesture until it is taken; while it is
// full and stalled, the input register holds any request it has and touch_stall
// is raised while it holds one.
// Reset is synchronous and restores the default register values and idle state.
module touch_gesture_detector (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         touch_valid,
  output logic                         touch_stall,
  input  logic                         touch_pressed,
  input  logic [tgd_pkg::CoordBits-1:0] point_x,
  input  logic [tgd_pkg::CoordBits-1:0] point_y,
  input  logic [tgd_pkg::TimeBits-1:0] now_ms,
  input  logic                         target_clickable,
  output logic                         gesture_valid,
  input  logic                         gesture_stall,
  output logic [tgd_pkg::CodeBits-1:0] gesture_code,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tgd_pkg::AddrBits-1:0] paddr,
  input  logic [tgd_pkg::DataBits-1:0] pwdata,
  output logic [tgd_pkg::DataBits-1:0] prdata,
  output logic                         pready
);
  import tgd_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid, advance, abandon, accept;

  assign touch_stall = item_valid && !advance;
  assign accept = touch_valid && !touch_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.touch_pressed <= touch_pressed;
      item.point_x <= point_x;
      item.point_y <= point_y;
      item.now_ms <= now_ms;
      item.target_clickable <= target_clickable;
    end
  end

  tgd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .abandon (abandon)
  );

  tgd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .abandon       (abandon),
    .item_valid    (item_valid),
    .item          (item),
    .advance       (advance),
    .gesture_stall (gesture_stall),
    .gesture_valid (gesture_valid),
    .gesture_code  (gesture_code)
  );

endmodule
